// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk_i and idle while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define JBSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JBSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jbsl_pkg.sv =====
package jbsl_pkg;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned QDEPTH  = 4;

  localparam logic [63:0] SIG_LIMIT  = 64'd922337203685477579;
  localparam logic [63:0] INT_LIM_LO = 64'd922337203685477580;
  localparam logic [63:0] INT_LIM_HI = 64'd922337203685477579;

  typedef enum logic [3:0] {
    TK_OBJ_OPEN  = 4'd0,
    TK_OBJ_CLOSE = 4'd1,
    TK_ARR_OPEN  = 4'd2,
    TK_ARR_CLOSE = 4'd3,
    TK_COLON     = 4'd4,
    TK_COMMA     = 4'd5,
    TK_STR_BYTE  = 4'd6,
    TK_STR_END   = 4'd7,
    TK_INT       = 4'd8,
    TK_REAL      = 4'd9,
    TK_TRUE      = 4'd10,
    TK_FALSE     = 4'd11,
    TK_NULL      = 4'd12,
    TK_END       = 4'd13,
    TK_ERROR     = 4'd14
  } tok_e;

  typedef enum logic [4:0] {
    M_VALUE, M_POST, M_STR, M_ESC, M_HEX, M_SURR_BS, M_SURR_U, M_HEX2, M_UTF8,
    M_LIT, M_NSIGN, M_NZERO, M_NINT, M_NDOT, M_NFRAC, M_NE, M_NESIGN, M_NEXP,
    M_HALT
  } mode_e;

  typedef struct packed {
    logic [2:0]                 cnt;
    logic [MAX_RES-1:0][3:0]    kind;
    logic [MAX_RES-1:0][7:0]    sbyte;
    logic [63:0]                num;
    logic [15:0]                expo;
    logic [31:0]                line;
  } run_t;

  function automatic run_t push(run_t r, tok_e k, logic [7:0] b);
    run_t o;
    o = r;
    if (r.cnt != 3'(MAX_RES)) begin
      o.kind[r.cnt[1:0]]  = k;
      o.sbyte[r.cnt[1:0]] = b;
      o.cnt               = r.cnt + 3'd1;
    end
    return o;
  endfunction

  function automatic logic [2:0] enc_len(logic [20:0] cp);
    logic [2:0] n;
    if (cp < 21'h80) n = 3'd1;
    else if (cp < 21'h800) n = 3'd2;
    else if (cp < 21'h10000) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  function automatic run_t push_cp(run_t r, logic [20:0] cp);
    run_t o;
    o = r;
    unique case (enc_len(cp))
      3'd1: o = push(o, TK_STR_BYTE, cp[7:0]);
      3'd2: begin
        o = push(o, TK_STR_BYTE, {3'b110, cp[10:6]});
        o = push(o, TK_STR_BYTE, {2'b10, cp[5:0]});
      end
      3'd3: begin
        o = push(o, TK_STR_BYTE, {4'b1110, cp[15:12]});
        o = push(o, TK_STR_BYTE, {2'b10, cp[11:6]});
        o = push(o, TK_STR_BYTE, {2'b10, cp[5:0]});
      end
      default: begin
        o = push(o, TK_STR_BYTE, {5'b11110, cp[20:18]});
        o = push(o, TK_STR_BYTE, {2'b10, cp[17:12]});
        o = push(o, TK_STR_BYTE, {2'b10, cp[11:6]});
        o = push(o, TK_STR_BYTE, {2'b10, cp[5:0]});
      end
    endcase
    return o;
  endfunction

  // bit 4 flags a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") r = {1'b1, b[3:0]};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - 8'h57)};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] sel);
    logic [2:0] n;
    unique case (sel)
      2'd0:    n = 3'd4;
      2'd1:    n = 3'd5;
      2'd2:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] sel, logic [2:0] pos);
    logic [7:0] c;
    unique case ({sel, pos})
      5'b00_000: c = "t";
      5'b00_001: c = "r";
      5'b00_010: c = "u";
      5'b00_011: c = "e";
      5'b01_000: c = "f";
      5'b01_001: c = "a";
      5'b01_010: c = "l";
      5'b01_011: c = "s";
      5'b01_100: c = "e";
      5'b10_000: c = "n";
      5'b10_001: c = "u";
      5'b10_010: c = "l";
      5'b10_011: c = "l";
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic tok_e lit_kind(logic [1:0] sel);
    tok_e k;
    unique case (sel)
      2'd0:    k = TK_TRUE;
      2'd1:    k = TK_FALSE;
      default: k = TK_NULL;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/jbsl_if.sv =====
interface jbsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jbsl_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [7:0]         string_byte;
  logic signed [63:0] number_value;
  logic signed [15:0] decimal_exponent;
  logic [31:0]        line_number;
  logic               last_of_run;

  modport source (output valid, output token_kind, output string_byte, output number_value,
                  output decimal_exponent, output line_number, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input string_byte, input number_value,
                  input decimal_exponent, input line_number, input last_of_run,
                  output ready);
endinterface

// ===== hdl/jbsl_front.sv =====
module jbsl_front #(
  parameter int unsigned MAX_SIG_DIGITS = 19
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic             ready_i,
  input  logic [7:0]       text_byte_i,
  input  logic             end_of_text_i,
  output logic             push_o,
  output jbsl_pkg::run_t   run_o
);

  localparam int unsigned SCW = $clog2(MAX_SIG_DIGITS + 1);

  jbsl_pkg::mode_e mode_q, mode_d;
  logic [15:0]     hex_q, hex_d;
  logic [1:0]      hcnt_q, hcnt_d;
  logic [9:0]      hi_q, hi_d;
  logic [20:0]     ucode_q, ucode_d;
  logic [2:0]      ulen_q, ulen_d;
  logic [1:0]      upend_q, upend_d;
  logic [63:0]     int_q, int_d;
  logic [63:0]     sig_q, sig_d;
  logic [15:0]     exp_q, exp_d;
  logic [15:0]     frac_q, frac_d;
  logic [15:0]     drop_q, drop_d;
  logic [SCW-1:0]  scnt_q, scnt_d;
  logic            neg_q, neg_d;
  logic            real_q, real_d;
  logic            eneg_q, eneg_d;
  logic [1:0]      lsel_q, lsel_d;
  logic [2:0]      lpos_q, lpos_d;
  logic [31:0]     line_q, line_d;

  jbsl_pkg::run_t  run;
  logic [7:0]      b;
  logic [3:0]      dv;
  logic            dig, ws;
  logic            do_int, do_frac, do_exp, do_finish, do_post, do_fail, do_end, rest;
  logic [63:0]     int10, sig10, mag;
  logic            int_ovf, sig_full;
  logic [15:0]     exp_new;
  logic signed [18:0] e_sum;
  logic [15:0]     e_sat;
  logic [4:0]      hv;
  logic [15:0]     hex_n;
  logic [20:0]     ucode_n, cp2;
  logic [1:0]      upend_n;
  logic [2:0]      lpos_n;
  logic            accept;

  assign accept = valid_i && ready_i;
  assign b      = text_byte_i;
  assign dig    = (b >= "0") && (b <= "9");
  assign dv     = dig ? b[3:0] : 4'd0;
  assign ws     = (b == " ") || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);

  assign int10    = (int_q << 3) + (int_q << 1) + 64'(dv);
  assign sig10    = (sig_q << 3) + (sig_q << 1) + 64'(dv);
  assign int_ovf  = int_q > ((dv <= 4'd7) ? jbsl_pkg::INT_LIM_LO : jbsl_pkg::INT_LIM_HI);
  assign sig_full = (scnt_q >= SCW'(MAX_SIG_DIGITS)) || (sig_q > jbsl_pkg::SIG_LIMIT);
  assign exp_new  = (exp_q > ((dv <= 4'd5) ? 16'd6553 : 16'd6552)) ? 16'hFFFF
                  : 16'((exp_q << 3) + (exp_q << 1) + 16'(dv));

  assign e_sum = (eneg_q ? -$signed({3'b000, exp_q}) : $signed({3'b000, exp_q}))
               + $signed({3'b000, drop_q}) - $signed({3'b000, frac_q});
  assign e_sat = (e_sum > 19'sd32767) ? 16'h7FFF
               : (e_sum < -19'sd32768) ? 16'h8000 : e_sum[15:0];
  assign mag   = real_q ? sig_q : int_q;

  assign hv      = jbsl_pkg::hex_val(b);
  assign hex_n   = {hex_q[11:0], hv[3:0]};
  assign ucode_n = {ucode_q[14:0], b[5:0]};
  assign upend_n = upend_q - 2'd1;
  assign cp2     = 21'h10000 + {1'b0, hi_q, hex_n[9:0]};
  assign lpos_n  = lpos_q + 3'd1;

  always_comb begin
    mode_d  = mode_q;
    hex_d   = hex_q;
    hcnt_d  = hcnt_q;
    hi_d    = hi_q;
    ucode_d = ucode_q;
    ulen_d  = ulen_q;
    upend_d = upend_q;
    int_d   = int_q;
    sig_d   = sig_q;
    exp_d   = exp_q;
    frac_d  = frac_q;
    drop_d  = drop_q;
    scnt_d  = scnt_q;
    neg_d   = neg_q;
    real_d  = real_q;
    eneg_d  = eneg_q;
    lsel_d  = lsel_q;
    lpos_d  = lpos_q;
    line_d  = line_q;
    run      = '0;
    run.line = line_q;
    do_int = 1'b0; do_frac = 1'b0; do_exp = 1'b0; do_finish = 1'b0;
    do_post = 1'b0; do_fail = 1'b0; do_end = 1'b0; rest = 1'b0;

    if (end_of_text_i) begin
      unique case (mode_q)
        jbsl_pkg::M_HALT: ;
        jbsl_pkg::M_VALUE, jbsl_pkg::M_POST: do_end = 1'b1;
        jbsl_pkg::M_NZERO, jbsl_pkg::M_NINT, jbsl_pkg::M_NFRAC, jbsl_pkg::M_NEXP: begin
          do_finish = 1'b1;
          do_end    = 1'b1;
        end
        default: do_fail = 1'b1;
      endcase
    end else begin
      unique case (mode_q)
        jbsl_pkg::M_HALT: ;
        jbsl_pkg::M_VALUE: begin
          if (ws) begin
            if (b == 8'h0A && line_q != 32'hFFFF_FFFF) line_d = line_q + 32'd1;
          end else begin
            priority case (b)
              "{": run = jbsl_pkg::push(run, jbsl_pkg::TK_OBJ_OPEN, 8'h00);
              "[": run = jbsl_pkg::push(run, jbsl_pkg::TK_ARR_OPEN, 8'h00);
              "}": begin
                run    = jbsl_pkg::push(run, jbsl_pkg::TK_OBJ_CLOSE, 8'h00);
                mode_d = jbsl_pkg::M_POST;
              end
              "]": begin
                run    = jbsl_pkg::push(run, jbsl_pkg::TK_ARR_CLOSE, 8'h00);
                mode_d = jbsl_pkg::M_POST;
              end
              "\"": mode_d = jbsl_pkg::M_STR;
              "t", "f", "n": begin
                lsel_d = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
                lpos_d = 3'd1;
                mode_d = jbsl_pkg::M_LIT;
              end
              default: begin
                if (b == "-" || dig) begin
                  int_d  = 64'(dv);
                  sig_d  = 64'(dv);
                  scnt_d = (dv != 4'd0) ? SCW'(1) : SCW'(0);
                  exp_d  = '0;
                  frac_d = '0;
                  drop_d = '0;
                  neg_d  = (b == "-");
                  real_d = 1'b0;
                  eneg_d = 1'b0;
                  mode_d = (b == "-") ? jbsl_pkg::M_NSIGN
                         : (b == "0") ? jbsl_pkg::M_NZERO : jbsl_pkg::M_NINT;
                end else begin
                  do_fail = 1'b1;
                end
              end
            endcase
          end
        end
        jbsl_pkg::M_POST: do_post = 1'b1;
        jbsl_pkg::M_STR: begin
          if (b < 8'h20 || b == 8'h7F) begin
            do_fail = 1'b1;
          end else if (b == "\"") begin
            run    = jbsl_pkg::push(run, jbsl_pkg::TK_STR_END, 8'h00);
            mode_d = jbsl_pkg::M_POST;
          end else if (b == "\\") begin
            mode_d = jbsl_pkg::M_ESC;
          end else if (b < 8'h80) begin
            run = jbsl_pkg::push(run, jbsl_pkg::TK_STR_BYTE, b);
          end else if (b[7:5] == 3'b110) begin
            ulen_d = 3'd2; ucode_d = 21'(b[4:0]); upend_d = 2'd1; mode_d = jbsl_pkg::M_UTF8;
          end else if (b[7:4] == 4'b1110) begin
            ulen_d = 3'd3; ucode_d = 21'(b[3:0]); upend_d = 2'd2; mode_d = jbsl_pkg::M_UTF8;
          end else if (b[7:3] == 5'b11110) begin
            ulen_d = 3'd4; ucode_d = 21'(b[2:0]); upend_d = 2'd3; mode_d = jbsl_pkg::M_UTF8;
          end else begin
            do_fail = 1'b1;
          end
        end
        jbsl_pkg::M_UTF8: begin
          if (b[7:6] != 2'b10) begin
            do_fail = 1'b1;
          end else begin
            ucode_d = ucode_n;
            upend_d = upend_n;
            if (upend_n == 2'd0) begin
              if (jbsl_pkg::enc_len(ucode_n) != ulen_q || ucode_n >= 21'h110000 ||
                  (ucode_n & 21'h1FF800) == 21'h00D800 ||
                  (ucode_n >= 21'h00FDD0 && ucode_n <= 21'h00FDEF) ||
                  (ucode_n & 21'h00FFFE) == 21'h00FFFE) begin
                do_fail = 1'b1;
              end else begin
                run    = jbsl_pkg::push_cp(run, ucode_n);
                mode_d = jbsl_pkg::M_STR;
              end
            end
          end
        end
        jbsl_pkg::M_ESC: begin
          priority case (b)
            "\"", "\\", "/": begin
              run = jbsl_pkg::push(run, jbsl_pkg::TK_STR_BYTE, b); mode_d = jbsl_pkg::M_STR;
            end
            "b": begin
              run = jbsl_pkg::push(run, jbsl_pkg::TK_STR_BYTE, 8'h08); mode_d = jbsl_pkg::M_STR;
            end
            "f": begin
              run = jbsl_pkg::push(run, jbsl_pkg::TK_STR_BYTE, 8'h0C); mode_d = jbsl_pkg::M_STR;
            end
            "n": begin
              run = jbsl_pkg::push(run, jbsl_pkg::TK_STR_BYTE, 8'h0A); mode_d = jbsl_pkg::M_STR;
            end
            "r": begin
              run = jbsl_pkg::push(run, jbsl_pkg::TK_STR_BYTE, 8'h0D); mode_d = jbsl_pkg::M_STR;
            end
            "t": begin
              run = jbsl_pkg::push(run, jbsl_pkg::TK_STR_BYTE, 8'h09); mode_d = jbsl_pkg::M_STR;
            end
            "u": begin
              hex_d = '0; hcnt_d = '0; mode_d = jbsl_pkg::M_HEX;
            end
            default: do_fail = 1'b1;
          endcase
        end
        jbsl_pkg::M_HEX, jbsl_pkg::M_HEX2: begin
          if (!hv[4]) begin
            do_fail = 1'b1;
          end else begin
            hex_d  = hex_n;
            hcnt_d = hcnt_q + 2'd1;
            if (hcnt_q == 2'd3) begin
              if (hex_n == 16'h0000) begin
                do_fail = 1'b1;
              end else if (mode_q == jbsl_pkg::M_HEX) begin
                if (hex_n[15:11] != 5'b11011) begin
                  run    = jbsl_pkg::push_cp(run, 21'(hex_n));
                  mode_d = jbsl_pkg::M_STR;
                end else if (hex_n >= 16'hDC00) begin
                  do_fail = 1'b1;
                end else begin
                  hi_d   = hex_n[9:0];
                  mode_d = jbsl_pkg::M_SURR_BS;
                end
              end else if (hex_n[15:10] != 6'b110111) begin
                do_fail = 1'b1;
              end else begin
                run    = jbsl_pkg::push_cp(run, cp2);
                mode_d = jbsl_pkg::M_STR;
              end
            end
          end
        end
        jbsl_pkg::M_SURR_BS: begin
          if (b == "\\") mode_d = jbsl_pkg::M_SURR_U;
          else do_fail = 1'b1;
        end
        jbsl_pkg::M_SURR_U: begin
          if (b == "u") begin
            hex_d = '0; hcnt_d = '0; mode_d = jbsl_pkg::M_HEX2;
          end else begin
            do_fail = 1'b1;
          end
        end
        jbsl_pkg::M_LIT: begin
          if (lpos_q >= jbsl_pkg::lit_len(lsel_q) || b != jbsl_pkg::lit_char(lsel_q, lpos_q)) begin
            do_fail = 1'b1;
          end else begin
            lpos_d = lpos_n;
            if (lpos_n == jbsl_pkg::lit_len(lsel_q)) begin
              run    = jbsl_pkg::push(run, jbsl_pkg::lit_kind(lsel_q), 8'h00);
              mode_d = jbsl_pkg::M_POST;
            end
          end
        end
        jbsl_pkg::M_NSIGN: begin
          if (b == "0") mode_d = jbsl_pkg::M_NZERO;
          else if (dig) begin
            do_int = 1'b1; mode_d = jbsl_pkg::M_NINT;
          end else do_fail = 1'b1;
        end
        jbsl_pkg::M_NDOT: begin
          if (dig) begin
            do_frac = 1'b1; mode_d = jbsl_pkg::M_NFRAC;
          end else do_fail = 1'b1;
        end
        jbsl_pkg::M_NE: begin
          if (b == "-") begin
            eneg_d = 1'b1; mode_d = jbsl_pkg::M_NESIGN;
          end else if (b == "+") begin
            mode_d = jbsl_pkg::M_NESIGN;
          end else if (dig) begin
            do_exp = 1'b1; mode_d = jbsl_pkg::M_NEXP;
          end else do_fail = 1'b1;
        end
        jbsl_pkg::M_NESIGN: begin
          if (dig) begin
            do_exp = 1'b1; mode_d = jbsl_pkg::M_NEXP;
          end else do_fail = 1'b1;
        end
        jbsl_pkg::M_NZERO: rest = 1'b1;
        jbsl_pkg::M_NINT: begin
          if (dig) do_int = 1'b1;
          else rest = 1'b1;
        end
        jbsl_pkg::M_NFRAC: begin
          if (dig) do_frac = 1'b1;
          else rest = 1'b1;
        end
        jbsl_pkg::M_NEXP: begin
          if (dig) do_exp = 1'b1;
          else begin
            do_finish = 1'b1; do_post = 1'b1;
          end
        end
        default: do_fail = 1'b1;
      endcase
    end

    if (rest) begin
      if (b == "." && mode_q != jbsl_pkg::M_NFRAC) begin
        real_d = 1'b1; mode_d = jbsl_pkg::M_NDOT;
      end else if (b == "e" || b == "E") begin
        real_d = 1'b1; mode_d = jbsl_pkg::M_NE;
      end else begin
        do_finish = 1'b1; do_post = 1'b1;
      end
    end

    if (do_int) begin
      if (!real_q) begin
        if (int_ovf) real_d = 1'b1;
        else int_d = int10;
      end
      if (sig_full) begin
        if (drop_q != 16'hFFFF) drop_d = drop_q + 16'd1;
      end else begin
        sig_d = sig10;
        if (sig10 != 64'd0) scnt_d = scnt_q + SCW'(1);
      end
    end
    if (do_frac && !sig_full) begin
      sig_d = sig10;
      if (frac_q != 16'hFFFF) frac_d = frac_q + 16'd1;
      if (sig10 != 64'd0) scnt_d = scnt_q + SCW'(1);
    end
    if (do_exp) exp_d = exp_new;

    if (do_finish) begin
      run      = jbsl_pkg::push(run, real_q ? jbsl_pkg::TK_REAL : jbsl_pkg::TK_INT, 8'h00);
      run.num  = neg_q ? (64'd0 - mag) : mag;
      run.expo = real_q ? e_sat : 16'd0;
      mode_d   = jbsl_pkg::M_POST;
    end

    if (do_post) begin
      if (ws) begin
        if (b == 8'h0A && line_q != 32'hFFFF_FFFF) line_d = line_q + 32'd1;
      end else begin
        priority case (b)
          ":": begin
            run = jbsl_pkg::push(run, jbsl_pkg::TK_COLON, 8'h00); mode_d = jbsl_pkg::M_VALUE;
          end
          ",": begin
            run = jbsl_pkg::push(run, jbsl_pkg::TK_COMMA, 8'h00); mode_d = jbsl_pkg::M_VALUE;
          end
          "}": begin
            run = jbsl_pkg::push(run, jbsl_pkg::TK_OBJ_CLOSE, 8'h00); mode_d = jbsl_pkg::M_POST;
          end
          "]": begin
            run = jbsl_pkg::push(run, jbsl_pkg::TK_ARR_CLOSE, 8'h00); mode_d = jbsl_pkg::M_POST;
          end
          default: do_fail = 1'b1;
        endcase
      end
    end

    if (do_fail) begin
      run    = jbsl_pkg::push(run, jbsl_pkg::TK_ERROR, 8'h00);
      mode_d = jbsl_pkg::M_HALT;
    end
    if (do_end) run = jbsl_pkg::push(run, jbsl_pkg::TK_END, 8'h00);
  end

  assign push_o = accept && (run.cnt != 3'd0);
  assign run_o  = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jbsl_pkg::M_VALUE;
      hex_q   <= '0;
      hcnt_q  <= '0;
      hi_q    <= '0;
      ucode_q <= '0;
      ulen_q  <= '0;
      upend_q <= '0;
      int_q   <= '0;
      sig_q   <= '0;
      exp_q   <= '0;
      frac_q  <= '0;
      drop_q  <= '0;
      scnt_q  <= '0;
      neg_q   <= 1'b0;
      real_q  <= 1'b0;
      eneg_q  <= 1'b0;
      lsel_q  <= '0;
      lpos_q  <= '0;
      line_q  <= 32'd1;
    end else if (accept) begin
      mode_q  <= mode_d;
      hex_q   <= hex_d;
      hcnt_q  <= hcnt_d;
      hi_q    <= hi_d;
      ucode_q <= ucode_d;
      ulen_q  <= ulen_d;
      upend_q <= upend_d;
      int_q   <= int_d;
      sig_q   <= sig_d;
      exp_q   <= exp_d;
      frac_q  <= frac_d;
      drop_q  <= drop_d;
      scnt_q  <= scnt_d;
      neg_q   <= neg_d;
      real_q  <= real_d;
      eneg_q  <= eneg_d;
      lsel_q  <= lsel_d;
      lpos_q  <= lpos_d;
      line_q  <= line_d;
    end
  end

endmodule

// ===== hdl/jbsl_queue.sv =====
module jbsl_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jbsl_pkg::run_t     run_i,
  output logic               ready_o,
  jbsl_out_if.source         out_o
);

  localparam int unsigned PW = $clog2(jbsl_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(jbsl_pkg::QDEPTH + 1);

  jbsl_pkg::run_t mem_q [jbsl_pkg::QDEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [1:0]     idx_q, idx_d;
  jbsl_pkg::run_t head;
  logic           last, pop;

  assign ready_o = (cnt_q != CW'(jbsl_pkg::QDEPTH));
  assign head    = mem_q[rd_q];
  assign last    = ({1'b0, idx_q} == (head.cnt - 3'd1));
  assign pop     = out_o.valid && out_o.ready && last;

  assign out_o.valid            = (cnt_q != '0);
  assign out_o.token_kind       = head.kind[idx_q];
  assign out_o.string_byte      = head.sbyte[idx_q];
  assign out_o.number_value     = (idx_q == 2'd0) ? head.num : 64'sd0;
  assign out_o.decimal_exponent = (idx_q == 2'd0) ? head.expo : 16'sd0;
  assign out_o.line_number      = head.line;
  assign out_o.last_of_run      = last;

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop);
    idx_d = idx_q;
    if (out_o.valid && out_o.ready) idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= run_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

endmodule

// ===== hdl/json_byte_stream_lexer.sv =====
// Output: the tokens of a text beat are registered in the queue when the beat is taken, then presented.
// Throughput: one text beat per cycle while the queue is not full; the tokens of a beat are
// presented in turn from one entry of a four-entry queue of token runs between the lexer and
// the output, which sets how far input runs ahead.
// Reset: asynchronous, active low; value mode, line count 1, queue empty, all counters zero.
module json_byte_stream_lexer #(
  parameter int unsigned MAX_SIG_DIGITS = 19
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jbsl_in_if.sink     in_i,
  jbsl_out_if.source  out_o
);

  logic           push;
  logic           q_ready;
  jbsl_pkg::run_t run;

  assign in_i.ready = q_ready;

  jbsl_front #(
    .MAX_SIG_DIGITS (MAX_SIG_DIGITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .ready_i       (q_ready),
    .text_byte_i   (in_i.text_byte),
    .end_of_text_i (in_i.end_of_text),
    .push_o        (push),
    .run_o         (run)
  );

  jbsl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .run_i   (run),
    .ready_o (q_ready),
    .out_o   (out_o)
  );

endmodule

// ===== hdl/jbsl_checker.sv =====
`include "assert_macros.svh"

module jbsl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  kind_i,
  input logic [7:0]  sbyte_i,
  input logic [15:0] expo_i
);

  `JBSL_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(kind_i) && $stable(sbyte_i), "token changed under stall")

  `JBSL_ASSERT_NEXT(a_error_halts, out_valid_i && out_ready_i && kind_i == jbsl_pkg::TK_ERROR,
    !out_valid_i, "token after error")

  `JBSL_ASSERT_NOW(a_byte_zero, out_valid_i && kind_i != jbsl_pkg::TK_STR_BYTE,
    sbyte_i == 8'h00, "string byte set on non-byte token")

  `JBSL_ASSERT_NOW(a_expo_zero, out_valid_i && kind_i != jbsl_pkg::TK_REAL,
    expo_i == 16'h0000, "exponent set on non-real token")

endmodule

bind json_byte_stream_lexer jbsl_checker u_jbsl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.token_kind),
  .sbyte_i     (out_o.string_byte),
  .expo_i      (out_o.decimal_exponent)
);

// ===== dv/tb_json_byte_stream_lexer.sv =====
`timescale 1ns / 1ps

module tb_json_byte_stream_lexer;

  localparam int unsigned SIG_DIGITS  = 19;
  localparam bit [63:0]   SIG_CAP     = 64'd922337203685477579;
  localparam bit [63:0]   INT_TOP     = 64'd9223372036854775807;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam bit [3:0] FL_NEG    = 4'd1;
  localparam bit [3:0] FL_REAL   = 4'd2;
  localparam bit [3:0] FL_EXPNEG = 4'd4;

  typedef struct {
    jbsl_pkg::tok_e kind;
    bit [7:0]       sbyte;
    bit [63:0]      num;
    bit [15:0]      expo;
    bit [31:0]      line;
    bit             last;
  } token_t;

  class token_scoreboard;
    jbsl_pkg::mode_e mode;
    bit [15:0] hex_acc, hi_surr, eacc, fdig, dropped;
    bit [7:0]  u8_pend, scount;
    bit [63:0] iacc, sacc;
    bit [3:0]  flags;
    bit [2:0]  lpos, hcnt, u8_len;
    bit [1:0]  lsel;
    bit [31:0] line, u8_code;
    token_t    burst[$];
    token_t    expected_tokens[$];
    int        mismatches;
    string     lit_words[3];

    function new();
      lit_words = '{"true", "false", "null"};
      mode = jbsl_pkg::M_VALUE;
      line = 1;
      mismatches = 0;
    endfunction

    function void emit(jbsl_pkg::tok_e k, bit [7:0] b, bit [63:0] v, bit [15:0] x);
      token_t t;
      if (burst.size() >= 4) return;
      t.kind = k; t.sbyte = b; t.num = v; t.expo = x; t.line = line; t.last = 0;
      burst.push_back(t);
    endfunction

    function void fail();
      emit(jbsl_pkg::TK_ERROR, 0, 0, 0);
      mode = jbsl_pkg::M_HALT;
    endfunction

    function int cp_len(bit [31:0] cp);
      if (cp < 32'h80) return 1;
      if (cp < 32'h800) return 2;
      if (cp < 32'h10000) return 3;
      if (cp < 32'h200000) return 4;
      if (cp < 32'h4000000) return 5;
      return 6;
    endfunction

    function void emit_cp(bit [31:0] cp);
      int n;
      bit [7:0] lead;
      n = cp_len(cp);
      if (n == 1) begin emit(jbsl_pkg::TK_STR_BYTE, cp[7:0], 0, 0); return; end
      if (n > 4) return;
      lead = (n == 2) ? 8'hC0 : (n == 3) ? 8'hE0 : 8'hF0;
      emit(jbsl_pkg::TK_STR_BYTE, lead | 8'(cp >> (6 * (n - 1))), 0, 0);
      for (int i = n - 1; i > 0; i--)
        emit(jbsl_pkg::TK_STR_BYTE, 8'h80 | 8'((cp >> (6 * (i - 1))) & 32'h3F), 0, 0);
    endfunction

    function bit sig_full();
      return scount >= SIG_DIGITS || sacc > SIG_CAP;
    endfunction

    function bit [15:0] sat16(bit [15:0] v);
      return v == 16'hFFFF ? v : v + 16'd1;
    endfunction

    function void int_digit(bit [63:0] d);
      if (!(flags & FL_REAL)) begin
        if (iacc > (INT_TOP - d) / 10) flags |= FL_REAL;
        else iacc = iacc * 10 + d;
      end
      if (sig_full()) dropped = sat16(dropped);
      else begin
        sacc = sacc * 10 + d;
        if (sacc != 0) scount++;
      end
    endfunction

    function void frac_digit(bit [63:0] d);
      if (sig_full()) return;
      sacc = sacc * 10 + d;
      fdig = sat16(fdig);
      if (sacc != 0) scount++;
    endfunction

    function void exp_digit(bit [63:0] d);
      if (64'(eacc) > (64'd65535 - d) / 64'd10) eacc = 16'hFFFF;
      else eacc = 16'(64'(eacc) * 64'd10 + d);
    endfunction

    function void start_number(bit neg);
      iacc = 0; sacc = 0; eacc = 0; fdig = 0; dropped = 0; scount = 0;
      flags = neg ? FL_NEG : 4'd0;
    endfunction

    function void finish_number();
      int e;
      if (flags & FL_REAL) begin
        e = int'(eacc);
        if (flags & FL_EXPNEG) e = -e;
        e = e + int'(dropped) - int'(fdig);
        if (e > 32767) e = 32767;
        if (e < -32768) e = -32768;
        emit(jbsl_pkg::TK_REAL, 0, (flags & FL_NEG) ? -sacc : sacc, 16'(e));
      end else
        emit(jbsl_pkg::TK_INT, 0, (flags & FL_NEG) ? -iacc : iacc, 0);
      mode = jbsl_pkg::M_POST;
    endfunction

    function bit skip_ws(bit [7:0] b);
      if (b == " " || b == 8'h09 || b == 8'h0D) return 1;
      if (b == 8'h0A) begin
        if (line != 32'hFFFFFFFF) line++;
        return 1;
      end
      return 0;
    endfunction

    function void post_byte(bit [7:0] b);
      if (skip_ws(b)) return;
      if (b == ":") begin emit(jbsl_pkg::TK_COLON, 0, 0, 0); mode = jbsl_pkg::M_VALUE; end
      else if (b == ",") begin emit(jbsl_pkg::TK_COMMA, 0, 0, 0); mode = jbsl_pkg::M_VALUE; end
      else if (b == "}") begin
        emit(jbsl_pkg::TK_OBJ_CLOSE, 0, 0, 0); mode = jbsl_pkg::M_POST;
      end else if (b == "]") begin
        emit(jbsl_pkg::TK_ARR_CLOSE, 0, 0, 0); mode = jbsl_pkg::M_POST;
      end else fail();
    endfunction

    function void value_byte(bit [7:0] b);
      if (skip_ws(b)) return;
      if (b == "{") emit(jbsl_pkg::TK_OBJ_OPEN, 0, 0, 0);
      else if (b == "[") emit(jbsl_pkg::TK_ARR_OPEN, 0, 0, 0);
      else if (b == "}") begin
        emit(jbsl_pkg::TK_OBJ_CLOSE, 0, 0, 0); mode = jbsl_pkg::M_POST;
      end else if (b == "]") begin
        emit(jbsl_pkg::TK_ARR_CLOSE, 0, 0, 0); mode = jbsl_pkg::M_POST;
      end else if (b == "\"") mode = jbsl_pkg::M_STR;
      else if (b == "-") begin start_number(1); mode = jbsl_pkg::M_NSIGN; end
      else if (b == "0") begin start_number(0); mode = jbsl_pkg::M_NZERO; end
      else if (b == "t" || b == "f" || b == "n") begin
        lsel = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
        lpos = 1;
        mode = jbsl_pkg::M_LIT;
      end else if (b >= "1" && b <= "9") begin
        start_number(0);
        int_digit(64'(b - "0"));
        mode = jbsl_pkg::M_NINT;
      end else fail();
    endfunction

    function void str_byte(bit [7:0] b);
      if (b < 8'h20 || b == 8'h7F) begin fail(); return; end
      if (b == "\"") begin
        emit(jbsl_pkg::TK_STR_END, 0, 0, 0); mode = jbsl_pkg::M_POST; return;
      end
      if (b == "\\") begin mode = jbsl_pkg::M_ESC; return; end
      if (b < 8'h80) begin emit(jbsl_pkg::TK_STR_BYTE, b, 0, 0); return; end
      if ((b & 8'hE0) == 8'hC0) begin u8_len = 2; u8_code = b & 8'h1F; end
      else if ((b & 8'hF0) == 8'hE0) begin u8_len = 3; u8_code = b & 8'h0F; end
      else if ((b & 8'hF8) == 8'hF0) begin u8_len = 4; u8_code = b & 8'h07; end
      else begin fail(); return; end
      u8_pend = u8_len - 1;
      mode = jbsl_pkg::M_UTF8;
    endfunction

    function void utf8_cont(bit [7:0] b);
      bit [31:0] cp;
      if ((b & 8'hC0) != 8'h80) begin fail(); return; end
      u8_code = (u8_code << 6) | (b & 8'h3F);
      if (u8_pend > 0) u8_pend--;
      if (u8_pend != 0) return;
      cp = u8_code;
      if (cp_len(cp) != u8_len || cp >= 32'h110000 || (cp & 32'hFFFFF800) == 32'hD800 ||
          (cp >= 32'hFDD0 && cp <= 32'hFDEF) || (cp & 32'hFFFE) == 32'hFFFE) begin
        fail();
        return;
      end
      emit_cp(cp);
      mode = jbsl_pkg::M_STR;
    endfunction

    function void esc_byte(bit [7:0] b);
      bit [7:0] ch;
      if (b == "\"" || b == "\\" || b == "/") ch = b;
      else if (b == "b") ch = 8'h08;
      else if (b == "f") ch = 8'h0C;
      else if (b == "n") ch = 8'h0A;
      else if (b == "r") ch = 8'h0D;
      else if (b == "t") ch = 8'h09;
      else if (b == "u") begin hex_acc = 0; hcnt = 0; mode = jbsl_pkg::M_HEX; return; end
      else begin fail(); return; end
      emit(jbsl_pkg::TK_STR_BYTE, ch, 0, 0);
      mode = jbsl_pkg::M_STR;
    endfunction

    function void hex_byte(bit [7:0] b);
      bit [3:0] v;
      if (b >= "0" && b <= "9") v = 4'(b - "0");
      else if (b >= "a" && b <= "f") v = 4'(b - "a" + 10);
      else if (b >= "A" && b <= "F") v = 4'(b - "A" + 10);
      else begin fail(); return; end
      hex_acc = {hex_acc[11:0], v};
      hcnt++;
      if (hcnt < 4) return;
      if (hex_acc == 0) begin fail(); return; end
      if (mode == jbsl_pkg::M_HEX) begin
        if ((hex_acc & 16'hF800) != 16'hD800) begin
          emit_cp(32'(hex_acc)); mode = jbsl_pkg::M_STR;
        end else if (hex_acc >= 16'hDC00) fail();
        else begin hi_surr = hex_acc; mode = jbsl_pkg::M_SURR_BS; end
      end else begin
        if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin fail(); return; end
        emit_cp(32'h10000 + ((32'(hi_surr) - 32'hD800) << 10) + (32'(hex_acc) - 32'hDC00));
        mode = jbsl_pkg::M_STR;
      end
    endfunction

    function void num_byte(bit [7:0] b);
      bit dig;
      bit [63:0] d;
      dig = b >= "0" && b <= "9";
      d = dig ? 64'(b - "0") : 64'd0;
      case (mode)
        jbsl_pkg::M_NSIGN: begin
          if (b == "0") mode = jbsl_pkg::M_NZERO;
          else if (dig) begin int_digit(d); mode = jbsl_pkg::M_NINT; end
          else fail();
          return;
        end
        jbsl_pkg::M_NDOT: begin
          if (dig) begin frac_digit(d); mode = jbsl_pkg::M_NFRAC; end else fail();
          return;
        end
        jbsl_pkg::M_NE: begin
          if (b == "-") begin flags |= FL_EXPNEG; mode = jbsl_pkg::M_NESIGN; end
          else if (b == "+") mode = jbsl_pkg::M_NESIGN;
          else if (dig) begin exp_digit(d); mode = jbsl_pkg::M_NEXP; end
          else fail();
          return;
        end
        jbsl_pkg::M_NESIGN: begin
          if (dig) begin exp_digit(d); mode = jbsl_pkg::M_NEXP; end else fail();
          return;
        end
        jbsl_pkg::M_NINT: if (dig) begin int_digit(d); return; end
        jbsl_pkg::M_NFRAC: if (dig) begin frac_digit(d); return; end
        jbsl_pkg::M_NEXP: begin
          if (dig) begin exp_digit(d); return; end
          finish_number();
          post_byte(b);
          return;
        end
        default: ;
      endcase
      if (b == "." && mode != jbsl_pkg::M_NFRAC) begin
        flags |= FL_REAL; mode = jbsl_pkg::M_NDOT;
      end else if (b == "e" || b == "E") begin
        flags |= FL_REAL; mode = jbsl_pkg::M_NE;
      end else begin finish_number(); post_byte(b); end
    endfunction

    function void lex_byte(bit [7:0] b);
      case (mode)
        jbsl_pkg::M_HALT: ;
        jbsl_pkg::M_VALUE: value_byte(b);
        jbsl_pkg::M_POST: post_byte(b);
        jbsl_pkg::M_STR: str_byte(b);
        jbsl_pkg::M_ESC: esc_byte(b);
        jbsl_pkg::M_HEX, jbsl_pkg::M_HEX2: hex_byte(b);
        jbsl_pkg::M_SURR_BS: if (b == "\\") mode = jbsl_pkg::M_SURR_U; else fail();
        jbsl_pkg::M_SURR_U:
          if (b == "u") begin hex_acc = 0; hcnt = 0; mode = jbsl_pkg::M_HEX2; end
          else fail();
        jbsl_pkg::M_UTF8: utf8_cont(b);
        jbsl_pkg::M_LIT: begin
          if (lsel > 2 || lpos >= lit_words[lsel].len() || b != lit_words[lsel][lpos])
            fail();
          else begin
            lpos++;
            if (lpos == lit_words[lsel].len()) begin
              emit(lsel == 0 ? jbsl_pkg::TK_TRUE : lsel == 1 ? jbsl_pkg::TK_FALSE
                                                             : jbsl_pkg::TK_NULL, 0, 0, 0);
              mode = jbsl_pkg::M_POST;
            end
          end
        end
        default: num_byte(b);
      endcase
    endfunction

    function void note_beat(bit [7:0] b, bit eot);
      burst.delete();
      if (eot) begin
        case (mode)
          jbsl_pkg::M_HALT: ;
          jbsl_pkg::M_VALUE, jbsl_pkg::M_POST: emit(jbsl_pkg::TK_END, 0, 0, 0);
          jbsl_pkg::M_NZERO, jbsl_pkg::M_NINT, jbsl_pkg::M_NFRAC, jbsl_pkg::M_NEXP: begin
            finish_number();
            emit(jbsl_pkg::TK_END, 0, 0, 0);
          end
          default: fail();
        endcase
      end else
        lex_byte(b);
      if (burst.size() > 0) burst[burst.size() - 1].last = 1;
      foreach (burst[i]) expected_tokens.push_back(burst[i]);
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token kind %0d byte %h num %h exp %h line %0d last %b",
                 $time, got.kind, got.sbyte, got.num, got.expo, got.line, got.last);
        mismatches++;
        return;
      end
      want = expected_tokens.pop_front();
      if (want.kind != got.kind || want.sbyte != got.sbyte || want.num != got.num ||
          want.expo != got.expo || want.line != got.line || want.last != got.last) begin
        $display("%0t: expected kind %0d byte %h num %h exp %h line %0d last %b", $time,
                 want.kind, want.sbyte, want.num, want.expo, want.line, want.last);
        $display("%0t:   actual kind %0d byte %h num %h exp %h line %0d last %b", $time,
                 got.kind, got.sbyte, got.num, got.expo, got.line, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  jbsl_in_if  in_if ();
  jbsl_out_if out_if ();

  json_byte_stream_lexer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  token_scoreboard sb = new();
  int unsigned send_pct, recv_pct, cycles;
  bit       hold_go, holding;
  bit [8:0] beats[$];
  bit       post_mode;

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    wait (hold_go);
    holding = 1'b1;
    repeat (300) @(posedge clk_i);
    holding = 1'b0;
  end

  always @(posedge clk_i) begin
    token_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind = jbsl_pkg::tok_e'(out_if.token_kind);
      got.sbyte = out_if.string_byte;
      got.num = out_if.number_value;
      got.expo = out_if.decimal_exponent;
      got.line = out_if.line_number;
      got.last = out_if.last_of_run;
      sb.check_token(got);
    end
    if (holding) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_pct);
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) beats.push_back({1'b0, s[i]});
  endtask

  task automatic add_byte(bit [7:0] b);
    beats.push_back({1'b0, b});
  endtask

  task automatic add_hex4(bit [15:0] v);
    bit [7:0] c;
    string digits;
    digits = "0123456789abcdef";
    for (int i = 3; i >= 0; i--) begin
      c = digits[v[i*4 +: 4]];
      if (c >= "a" && $urandom_range(1)) c = c - 8'h20;
      add_byte(c);
    end
  endtask

  task automatic add_digits(int n, bit nonzero_first);
    for (int i = 0; i < n; i++)
      add_byte((i == 0 && nonzero_first) ? 8'("1" + $urandom_range(8))
                                         : 8'("0" + $urandom_range(9)));
  endtask

  task automatic add_utf8(bit [31:0] cp);
    if (cp < 32'h800) begin
      add_byte(8'hC0 | cp[10:6]); add_byte(8'h80 | cp[5:0]);
    end else if (cp < 32'h10000) begin
      add_byte(8'hE0 | cp[15:12]); add_byte(8'h80 | cp[11:6]); add_byte(8'h80 | cp[5:0]);
    end else begin
      add_byte(8'hF0 | cp[20:18]); add_byte(8'h80 | cp[17:12]);
      add_byte(8'h80 | cp[11:6]); add_byte(8'h80 | cp[5:0]);
    end
  endtask

  task automatic add_string();
    bit [7:0] c;
    bit [15:0] h;
    int n;
    string esc_set;
    esc_set = "\"\\/bfnrt";
    n = $urandom_range(6);
    add_byte("\"");
    repeat (n) begin
      case ($urandom_range(7))
        0, 1, 2: begin
          do c = 8'($urandom_range(8'h20, 8'h7E)); while (c == "\"" || c == "\\");
          add_byte(c);
        end
        3: begin
          add_byte("\\");
          add_byte(esc_set[$urandom_range(7)]);
        end
        4: begin
          do h = 16'($urandom_range(1, 16'hFFFF)); while (h[15:11] == 5'b11011);
          add_text("\\u"); add_hex4(h);
        end
        5: begin
          add_text("\\u"); add_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
          add_text("\\u"); add_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        6: begin
          if ($urandom_range(1)) add_utf8($urandom_range(32'h80, 32'h7FF));
          else add_utf8($urandom_range(32'h800, 32'hD7FF));
        end
        default: begin
          if ($urandom_range(1)) add_utf8($urandom_range(32'hE000, 32'hFDCF));
          else add_utf8(32'h10000 * $urandom_range(1, 16) + $urandom_range(16'hFFFD));
        end
      endcase
    end
    add_byte("\"");
  endtask

  task automatic add_number();
    if ($urandom_range(1)) add_byte("-");
    if ($urandom_range(4) == 0) add_byte("0");
    else add_digits(($urandom_range(7) == 0) ? $urandom_range(18, 25) : $urandom_range(1, 4), 1);
    if ($urandom_range(9) < 4) begin
      add_byte(".");
      add_digits(($urandom_range(7) == 0) ? $urandom_range(18, 25) : $urandom_range(1, 5), 0);
    end
    if ($urandom_range(9) < 3) begin
      add_byte($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: add_byte("-");
        1: add_byte("+");
        default: ;
      endcase
      add_digits(($urandom_range(5) == 0) ? 6 : $urandom_range(1, 3), 0);
    end
  endtask

  task automatic gen_text(int unsigned count);
    int unsigned goal;
    goal = beats.size() + count;
    while (beats.size() < goal) begin
      case ($urandom_range(9))
        0: add_byte(" ");
        1: add_byte(8'h0A);
        2: add_byte($urandom_range(1) ? 8'h09 : 8'h0D);
        default: ;
      endcase
      if ($urandom_range(24) == 0) beats.push_back(9'h100 | 9'($urandom_range(255)));
      else if (post_mode) begin
        case ($urandom_range(3))
          0: begin add_byte(":"); post_mode = 0; end
          1: begin add_byte(","); post_mode = 0; end
          2: add_byte("}");
          default: add_byte("]");
        endcase
      end else begin
        post_mode = 1;
        case ($urandom_range(9))
          0, 1, 2: add_string();
          3, 4, 5: add_number();
          6: begin
            case ($urandom_range(2))
              0: add_text("true");
              1: add_text("false");
              default: add_text("null");
            endcase
          end
          7: begin add_byte($urandom_range(1) ? "{" : "["); post_mode = 0; end
          default: add_byte($urandom_range(1) ? "}" : "]");
        endcase
      end
    end
  endtask

  task automatic send_beats();
    bit [8:0] bt;
    while (beats.size() > 0) begin
      bt = beats.pop_front();
      while ($urandom_range(99) < send_pct) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_if.valid <= 1'b1;
      in_if.text_byte <= bt[7:0];
      in_if.end_of_text <= bt[8];
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
      sb.note_beat(bt[7:0], bt[8]);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.text_byte <= 8'h00;
    in_if.end_of_text <= 1'b0;
    send_pct = 0;
    recv_pct = 0;
    post_mode = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_text("{\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\u00e9\\uD83D\\uDE00");
    add_utf8(32'hE9); add_utf8(32'h20AC); add_utf8(32'h10FFFD);
    add_text("\":[true,false,null,-0,0,9223372036854775807,9223372036854775808,");
    add_text("-12.5e-3,1E+99999,0.000123,1e-99999,12345678901234567890123.45]}\n");
    beats.push_back(9'h1FF);
    add_text(" 42");
    beats.push_back(9'h100);
    post_mode = 1;
    send_beats();

    send_pct = 35; recv_pct = 51;
    gen_text(50);
    send_beats();
    send_pct = 51; recv_pct = 35;
    gen_text(50);
    send_beats();
    send_pct = 0; recv_pct = 0;
    hold_go = 1'b1;
    gen_text(50);
    send_beats();

    case ($urandom_range(4))
      0: add_text("\"a\x01");
      1: add_text(post_mode ? ";" : "x");
      2: add_text(post_mode ? ",tru!" : "tru!");
      3: add_text(post_mode ? ",\"\\uD800x" : "\"\\uDC00");
      default: begin
        add_text(post_mode ? ",\"ab" : "\"ab");
        beats.push_back(9'h100);
      end
    endcase
    add_text("[1,2]");
    beats.push_back(9'h100);
    send_beats();

    while (sb.expected_tokens.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
